// File: design/filtered_stream_aggregator_core_defines.svh
// assertion macros for the filtered stream aggregator
`ifndef FILTERED_STREAM_AGGREGATOR_CORE_DEFINES_SVH
`define FILTERED_STREAM_AGGREGATOR_CORE_DEFINES_SVH

// checked at every clock edge outside reset
`define FSA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every clock edge, reset included
`define FSA_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// File: design/fsa_pkg.sv
// package: widths, mode codes and shared unit request type of the filtered stream aggregator
`timescale 1ns / 1ps

package fsa_pkg;

   localparam int VALUE_WIDTH = 64;
   localparam int COUNT_WIDTH = 32;
   localparam int OUT_WIDTH   = 64;
   localparam int UNIT_WIDTH  =
      ((VALUE_WIDTH > COUNT_WIDTH) ? VALUE_WIDTH : COUNT_WIDTH) + 2;
   localparam int STEP_WIDTH  = $clog2(VALUE_WIDTH);

   localparam logic [VALUE_WIDTH-1:0] VALUE_TOP    = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
   localparam logic [VALUE_WIDTH-1:0] VALUE_BOTTOM = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

   localparam logic [2:0] MODE_SUM     = 3'd0;
   localparam logic [2:0] MODE_COUNT   = 3'd1;
   localparam logic [2:0] MODE_AVERAGE = 3'd2;
   localparam logic [2:0] MODE_MINIMUM = 3'd3;
   localparam logic [2:0] MODE_MAXIMUM = 3'd4;

   typedef struct packed {
      logic [UNIT_WIDTH-1:0] operand_a;
      logic [UNIT_WIDTH-1:0] operand_b;
      logic                  subtract;
   } alu_req_type;

endpackage

// File: design/fsa_alu.sv
// shared add and subtract unit used for sum, compare, negate and divide steps
`timescale 1ns / 1ps

module fsa_alu
   import fsa_pkg::*;
(
   input  alu_req_type           alu_req,
   output logic [UNIT_WIDTH-1:0] alu_result
);

   assign alu_result = alu_req.operand_a
                     + (alu_req.operand_b ^ {UNIT_WIDTH{alu_req.subtract}})
                     + UNIT_WIDTH'(alu_req.subtract);

endmodule

// File: design/filtered_stream_aggregator_core.sv
// top level: sequencer, state registers and output register of the aggregator
//
// Input channel req_*: one sample per transaction with value, present bit,
// filter match bit and last mark. A sample is used only when present and
// matching. Output channel rsp_*: one aggregate per set, sent on the last
// sample. csr_write_enable/csr_write_data write the mode register.
// Every arithmetic step runs through one shared add/subtract unit, so the
// block takes one sample at a time and drops req_ready while it works:
//   unused sample, not last: accepted every cycle
//   used sample: accept, sum, minimum compare, maximum compare
//   last sample: a further step loads the output register; in average mode
//   (once a sample was used) negate, 64 restoring divide steps, negate first
// The result sits in an output register; while the receiver stalls,
// samples are still taken until one closes a set, then that set waits in
// the load step and req_ready stays low until the register frees up.
// Reset (synchronous) clears the mode to sum,
// empties all running state and drops rsp_valid; no clearing pass is needed.
`timescale 1ns / 1ps

module filtered_stream_aggregator_core
   import fsa_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [63:0]    req_sample_value,
   input  logic                  req_sample_present,
   input  logic                  req_tag_match,
   input  logic                  req_last_sample,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [63:0]    rsp_aggregate,
   output logic                  rsp_aggregate_valid,
   output logic                  rsp_saturated,
   input  logic                  csr_write_enable,
   input  logic [2:0]            csr_write_data
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_SUM    = 8'b0000_0010,
      ST_MIN    = 8'b0000_0100,
      ST_MAX    = 8'b0000_1000,
      ST_NEG1   = 8'b0001_0000,
      ST_DIV    = 8'b0010_0000,
      ST_NEG2   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   function automatic logic [UNIT_WIDTH-1:0] sext_unit(input logic [VALUE_WIDTH-1:0] x);
      return UNIT_WIDTH'(signed'(x));
   endfunction

   state_type               state_ff, state_in;
   logic [2:0]              mode_ff, mode_in;
   logic [VALUE_WIDTH-1:0]  sum_ff, sum_in;
   logic [COUNT_WIDTH-1:0]  count_ff, count_in;
   logic [VALUE_WIDTH-1:0]  min_ff, min_in;
   logic [VALUE_WIDTH-1:0]  max_ff, max_in;
   logic                    found_ff, found_in;
   logic                    sat_ff, sat_in;
   logic [VALUE_WIDTH-1:0]  value_ff, value_in;
   logic                    first_ff, first_in;
   logic                    last_ff, last_in;
   logic [VALUE_WIDTH-1:0]  quo_ff, quo_in;
   logic [COUNT_WIDTH-1:0]  rem_ff, rem_in;
   logic [STEP_WIDTH-1:0]   step_ff, step_in;
   logic                    neg_ff, neg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_WIDTH-1:0]    agg_ff, agg_in;
   logic                    agg_valid_ff, agg_valid_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   alu_req_type             alu_req;
   logic [UNIT_WIDTH-1:0]   alu_result;
   logic [COUNT_WIDTH:0]    rem_shift;
   logic                    usable;
   logic                    go_avg;

   fsa_alu u_alu (
      .alu_req    (alu_req),
      .alu_result (alu_result)
   );

   assign usable    = req_sample_present & req_tag_match;
   assign go_avg    = (mode_ff == MODE_AVERAGE) && found_ff;
   assign rem_shift = {rem_ff, quo_ff[VALUE_WIDTH-1]};

   always_comb begin
      state_in     = state_ff;
      mode_in      = csr_write_enable ? csr_write_data : mode_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      found_in     = found_ff;
      sat_in       = sat_ff;
      value_in     = value_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      neg_in       = neg_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      agg_in       = agg_ff;
      agg_valid_in = agg_valid_ff;
      rsp_sat_in   = rsp_sat_ff;
      alu_req      = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               value_in = req_sample_value[VALUE_WIDTH-1:0];
               first_in = ~found_ff;
               last_in  = req_last_sample;
               if (usable) begin
                  state_in = ST_SUM;
               end else if (req_last_sample) begin
                  state_in = go_avg ? ST_NEG1 : ST_FINISH;
               end
            end
         end
         ST_SUM: begin
            alu_req.operand_a = sext_unit(sum_ff);
            alu_req.operand_b = sext_unit(value_ff);
            alu_req.subtract  = 1'b0;
            if (alu_result[VALUE_WIDTH] != alu_result[VALUE_WIDTH-1]) begin
               sum_in = alu_result[VALUE_WIDTH] ? VALUE_BOTTOM : VALUE_TOP;
               sat_in = 1'b1;
            end else begin
               sum_in = alu_result[VALUE_WIDTH-1:0];
            end
            if (count_ff != '1) begin
               count_in = count_ff + COUNT_WIDTH'(1);
            end
            found_in = 1'b1;
            state_in = ST_MIN;
         end
         ST_MIN: begin
            alu_req.operand_a = sext_unit(value_ff);
            alu_req.operand_b = sext_unit(min_ff);
            alu_req.subtract  = 1'b1;
            if (first_ff || alu_result[UNIT_WIDTH-1]) begin
               min_in = value_ff;
            end
            state_in = ST_MAX;
         end
         ST_MAX: begin
            alu_req.operand_a = sext_unit(max_ff);
            alu_req.operand_b = sext_unit(value_ff);
            alu_req.subtract  = 1'b1;
            if (first_ff || alu_result[UNIT_WIDTH-1]) begin
               max_in = value_ff;
            end
            if (last_ff) begin
               state_in = go_avg ? ST_NEG1 : ST_FINISH;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_NEG1: begin
            alu_req.operand_a = '0;
            alu_req.operand_b = sext_unit(sum_ff);
            alu_req.subtract  = sum_ff[VALUE_WIDTH-1];
            quo_in   = alu_result[VALUE_WIDTH-1:0];
            neg_in   = sum_ff[VALUE_WIDTH-1];
            rem_in   = '0;
            step_in  = STEP_WIDTH'(VALUE_WIDTH - 1);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            alu_req.operand_a = UNIT_WIDTH'(rem_shift);
            alu_req.operand_b = UNIT_WIDTH'(count_ff);
            alu_req.subtract  = 1'b1;
            if (!alu_result[UNIT_WIDTH-1]) begin
               rem_in = alu_result[COUNT_WIDTH-1:0];
            end else begin
               rem_in = rem_shift[COUNT_WIDTH-1:0];
            end
            quo_in  = {quo_ff[VALUE_WIDTH-2:0], ~alu_result[UNIT_WIDTH-1]};
            step_in = step_ff - STEP_WIDTH'(1);
            if (step_ff == '0) begin
               state_in = ST_NEG2;
            end
         end
         ST_NEG2: begin
            alu_req.operand_a = '0;
            alu_req.operand_b = UNIT_WIDTH'(quo_ff);
            alu_req.subtract  = neg_ff;
            quo_in   = alu_result[VALUE_WIDTH-1:0];
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_sat_in   = sat_ff;
               unique case (mode_ff)
                  MODE_SUM: begin
                     agg_valid_in = found_ff;
                     agg_in       = found_ff ? OUT_WIDTH'(signed'(sum_ff)) : '0;
                  end
                  MODE_COUNT: begin
                     agg_valid_in = 1'b1;
                     agg_in       = OUT_WIDTH'(count_ff);
                  end
                  MODE_AVERAGE: begin
                     agg_valid_in = found_ff;
                     agg_in       = found_ff ? OUT_WIDTH'(signed'(quo_ff)) : '0;
                  end
                  MODE_MINIMUM: begin
                     agg_valid_in = found_ff;
                     agg_in       = found_ff ? OUT_WIDTH'(signed'(min_ff)) : '0;
                  end
                  MODE_MAXIMUM: begin
                     agg_valid_in = found_ff;
                     agg_in       = found_ff ? OUT_WIDTH'(signed'(max_ff)) : '0;
                  end
                  default: begin
                     agg_valid_in = 1'b0;
                     agg_in       = '0;
                  end
               endcase
               sum_in   = '0;
               count_in = '0;
               min_in   = '0;
               max_in   = '0;
               found_in = 1'b0;
               sat_in   = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_SUM;
         sum_ff       <= '0;
         count_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         found_ff     <= 1'b0;
         sat_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         found_ff     <= found_in;
         sat_ff       <= sat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff     <= value_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      quo_ff       <= quo_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      neg_ff       <= neg_in;
      agg_ff       <= agg_in;
      agg_valid_ff <= agg_valid_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   assign req_ready           = (state_ff == ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_aggregate       = agg_ff;
   assign rsp_aggregate_valid = agg_valid_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

// File: design/fsa_checker.sv
// port-level checker for the filtered stream aggregator, bound to the top level
`timescale 1ns / 1ps
`include "filtered_stream_aggregator_core_defines.svh"

module fsa_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               req_sample_present,
   input logic               req_tag_match,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [63:0] rsp_aggregate,
   input logic               rsp_saturated
);

   `FSA_ASSERT(rsp_hold_chk, rsp_valid && !rsp_ready |=> rsp_valid, "rsp_valid dropped while stalled")
   `FSA_ASSERT(rsp_stable_chk, rsp_valid && !rsp_ready |=> $stable(rsp_aggregate), "aggregate changed while stalled")
   `FSA_ASSERT_ALWAYS(reset_chk, reset |=> !rsp_valid, "rsp_valid high after reset")
   `FSA_ASSERT(busy_chk, req_valid && req_ready && req_sample_present && req_tag_match |=> !req_ready, "ready right after a used sample")

endmodule

bind filtered_stream_aggregator_core fsa_checker u_fsa_checker (.*);
